[sv/lmrf_pkg.sv]
// ----------------------------------------------------------------------------
// lmrf_pkg
// Shared types and constants of the lane-marking row filter.
// ----------------------------------------------------------------------------
`default_nettype none

package lmrf_pkg;

  localparam int unsigned PIX_W = 8;   // gray level width
  localparam int unsigned CFG_W = 5;   // window offset register width

  localparam logic [CFG_W-1:0] OFFSET_RESET = 5'd5;

  // Per-pixel decisions made at acceptance and carried to the result stage.
  typedef struct packed {
    logic valid;  // the input register holds a pixel
    logic emit;   // the pixel, as a right neighbour, completes a column result
    logic calc;   // that column lies inside the row, so the filter applies
    logic last;   // the pixel closes its row and triggers the flush
  } lmrf_flags_t;

endpackage

`default_nettype wire

[sv/lmrf_ram.sv]
// ----------------------------------------------------------------------------
// lmrf_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module lmrf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

[sv/lmrf_front.sv]
// ----------------------------------------------------------------------------
// lmrf_front
// Offset register, column counter, pixel history and the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module lmrf_front import lmrf_pkg::*; #(
  parameter int unsigned MaxOffset    = 16,
  parameter int unsigned MaxRowPixels = 4096
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [CFG_W-1:0]                 cfg_wdata_i,
  input  wire logic                             accept_i,
  input  wire logic [PIX_W-1:0]                 pixel_i,
  input  wire logic                             row_end_i,
  input  wire logic                             s1_ready_i,
  output lmrf_flags_t                           flags_o,
  output logic      [$clog2(MaxOffset+1):0]     count_o,
  output logic      [PIX_W-1:0]                 pix_r_o,
  output logic      [PIX_W-1:0]                 pix_c_o,
  output logic      [PIX_W-1:0]                 pix_l_o
);

  localparam int unsigned TauW  = $clog2(MaxOffset + 1);
  localparam int unsigned NumW  = TauW + 1;
  localparam int unsigned CntW  = $clog2(MaxRowPixels);
  localparam int unsigned AddrW = $clog2(2 * MaxOffset + 1);
  localparam int unsigned Depth = 2 ** AddrW;

  logic [CFG_W-1:0] cfg_q;
  logic [CntW-1:0]  col_q, col_d;
  logic [AddrW-1:0] wp_q;
  logic [TauW-1:0]  tau;
  logic [TauW-1:0]  flush;
  logic             last;
  lmrf_flags_t      flags_q, flags_d;
  logic [NumW-1:0]  count_q, count_d;
  logic [PIX_W-1:0] pix_r_q;
  logic [AddrW-1:0] raddr_c, raddr_l;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= OFFSET_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (cfg_q == '0) begin
      tau = TauW'(1);
    end else if (32'(cfg_q) > MaxOffset) begin
      tau = TauW'(MaxOffset);
    end else begin
      tau = TauW'(cfg_q);
    end

    last          = row_end_i || (32'(col_q) == MaxRowPixels - 1);
    flags_d.valid = accept_i;
    flags_d.emit  = 32'(col_q) >= 32'(tau);
    flags_d.calc  = 32'(col_q) >= 32'(tau) * 2;
    flags_d.last  = last;
    flush         = flags_d.emit ? tau : TauW'(32'(col_q) + 1);
    count_d       = NumW'(flags_d.emit) + (last ? NumW'(flush) : '0);
    col_d         = last ? '0 : col_q + CntW'(1);

    raddr_c = wp_q - AddrW'(tau);
    raddr_l = wp_q - AddrW'(32'(tau) * 2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      wp_q  <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      wp_q  <= wp_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (s1_ready_i) begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      count_q <= count_d;
      pix_r_q <= pixel_i;
    end
  end

  lmrf_ram #(
    .Width(PIX_W),
    .Depth(Depth)
  ) u_hist (
    .clk_i    (clk_i),
    .we_i     (accept_i),
    .waddr_i  (wp_q),
    .wdata_i  (pixel_i),
    .re_i     (accept_i),
    .raddr_a_i(raddr_c),
    .raddr_b_i(raddr_l),
    .rdata_a_o(pix_c_o),
    .rdata_b_o(pix_l_o)
  );

  assign flags_o = flags_q;
  assign count_o = count_q;
  assign pix_r_o = pix_r_q;

  a_col_wraps_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last |=> col_q == '0)
    else $error("column count not cleared after the row's last pixel");

  a_wp_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> wp_q == $past(wp_q) + AddrW'(1))
    else $error("history pointer did not advance on an accepted pixel");

  a_last_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.valid && flags_q.last |-> count_q != '0)
    else $error("row end pixel carries no result");

endmodule

`default_nettype wire

[sv/lmrf_emit.sv]
// ----------------------------------------------------------------------------
// lmrf_emit
// Filter arithmetic and result sequencer feeding the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lmrf_emit import lmrf_pkg::*; #(
  parameter int unsigned MaxOffset = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  lmrf_flags_t                       flags_i,
  input  wire logic [$clog2(MaxOffset+1):0] count_i,
  input  wire logic [PIX_W-1:0]             pix_r_i,
  input  wire logic [PIX_W-1:0]             pix_c_i,
  input  wire logic [PIX_W-1:0]             pix_l_i,
  output logic                              s1_ready_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [PIX_W-1:0]             out_value_o,
  output logic                              out_last_o
);

  localparam int unsigned NumW = $clog2(MaxOffset + 1) + 1;

  // clamp(2c - l - r - |l - r|, 0, 255), zero when the center is zero.
  function automatic logic [PIX_W-1:0] response(input logic [PIX_W-1:0] c,
                                                input logic [PIX_W-1:0] l,
                                                input logic [PIX_W-1:0] r);
    logic [PIX_W-1:0]   d;
    logic signed [10:0] acc;
    logic [PIX_W-1:0]   res;
    d   = (l > r) ? l - r : r - l;
    acc = $signed({2'b00, c, 1'b0}) - $signed({3'b000, l})
        - $signed({3'b000, r}) - $signed({3'b000, d});
    if (c == '0 || acc < 0) begin
      res = '0;
    end else if (acc > 11'sd255) begin
      res = '1;
    end else begin
      res = acc[PIX_W-1:0];
    end
    return res;
  endfunction

  logic [NumW-1:0]  idx_q;
  logic             out_valid_q;
  logic [PIX_W-1:0] out_value_q, value_d;
  logic             out_last_q, last_d;
  logic             out_free, push, last_push, s1_done;

  always_comb begin
    out_free   = !out_valid_q || out_ready_i;
    push       = flags_i.valid && (count_i != '0) && out_free;
    last_push  = idx_q == count_i - NumW'(1);
    s1_done    = flags_i.valid && ((count_i == '0) || (push && last_push));
    s1_ready_o = !flags_i.valid || s1_done;

    // The column result comes first; the row-end flush zeros follow it.
    value_d = '0;
    if (idx_q == '0 && flags_i.emit && flags_i.calc) begin
      value_d = response(pix_c_i, pix_l_i, pix_r_i);
    end
    last_d = flags_i.last && last_push;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (s1_done) begin
      idx_q <= '0;
    end else if (push) begin
      idx_q <= idx_q + NumW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_value_q <= value_d;
      out_last_q  <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_i.valid && count_i != '0 |-> idx_q < count_i)
    else $error("result index ran past the pixel's result count");

  a_idx_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_done |=> idx_q == '0)
    else $error("result index not restarted for the next pixel");

  a_row_done_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && last_d |=> out_valid_q && out_last_q && out_value_q == '0)
    else $error("row end beat is not a flushed zero");

endmodule

`default_nettype wire

[sv/lane_marking_row_filter.sv]
// ----------------------------------------------------------------------------
// lane_marking_row_filter
// Horizontal lane-marking filter over a raster stream of gray pixels.
// ----------------------------------------------------------------------------
// Pixels arrive one per beat in raster order, with tlast on the last pixel of
// each row. For a column x with tau neighbours on both sides the block returns
// clamp(2c - l - r - |l - r|, 0, 255), where c is pixel x, l is pixel x-tau and
// r is pixel x+tau; a zero center and the tau border columns on each side give
// zero. A column's result leaves as soon as its right neighbour has arrived,
// so results trail the input by tau beats, and at the end of a row the
// trailing columns are flushed as zeros with tlast on the final one. A row
// thus gives as many result beats as it had pixels; a row of at most tau
// pixels gives all its zeros at its last pixel. tau is the window offset
// register (reset 5); a value of zero acts as one, a value above MaxOffset
// acts as MaxOffset, and it should only be written while the block is idle.
// A row longer than MaxRowPixels is cut after that many pixels as if tlast
// had been set. Throughput is one pixel per clock: a pixel is registered
// together with its two neighbours read from a small two-read-port history
// RAM, the filter arithmetic runs between that register and the output
// register, and a new pixel is taken every cycle that the output can move.
// Only the row-end pixel holds the input, for the extra flush beats it
// produces. A column's result is computed from the input register once its
// right neighbour is accepted and is then held in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lane_marking_row_filter import lmrf_pkg::*; #(
  parameter int unsigned MaxOffset    = 16,
  parameter int unsigned MaxRowPixels = 4096
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Window offset register write.
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  // Pixel input stream.
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,   // [7:0] pixel_value
  input  wire logic             s_axis_tlast,   // row_end
  // Filtered output stream.
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [7:0]       m_axis_tdata,   // [7:0] filtered_value
  output logic                  m_axis_tlast    // row_done
);

  localparam int unsigned NumW = $clog2(MaxOffset + 1) + 1;

  lmrf_flags_t      flags;
  logic [NumW-1:0]  count;
  logic [PIX_W-1:0] pix_r, pix_c, pix_l;
  logic             s1_ready;
  logic             accept;

  // A beat is taken whenever the input register is free or empties this cycle.
  assign s_axis_tready = s1_ready;
  assign accept        = s_axis_tvalid && s1_ready;

  lmrf_front #(
    .MaxOffset   (MaxOffset),
    .MaxRowPixels(MaxRowPixels)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .pixel_i    (s_axis_tdata),
    .row_end_i  (s_axis_tlast),
    .s1_ready_i (s1_ready),
    .flags_o    (flags),
    .count_o    (count),
    .pix_r_o    (pix_r),
    .pix_c_o    (pix_c),
    .pix_l_o    (pix_l)
  );

  lmrf_emit #(
    .MaxOffset(MaxOffset)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .flags_i    (flags),
    .count_i    (count),
    .pix_r_i    (pix_r),
    .pix_c_i    (pix_c),
    .pix_l_i    (pix_l),
    .s1_ready_o (s1_ready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_value_o(m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lane-marking row filter.
// ----------------------------------------------------------------------------
// Rows of gray pixels are pushed into the pixel stream. A scoreboard keeps its
// own copy of the pixel history, the column counter and the window offset.
// For every accepted pixel it predicts the filter beats that pixel releases.
// Every beat that leaves the block is compared with the oldest prediction.
// The run starts with hand-picked rows: both clamp limits, a zero center,
// offsets at and beyond both ends of their range and rows shorter than the
// window. Random rows follow, each group under a freshly written offset.
// Both stream sides idle at random, the receiver once holds off long enough
// to back the block up, and the offset is only rewritten once the block has
// drained.
// ----------------------------------------------------------------------------
module tb;
  import lmrf_pkg::*;

  localparam int unsigned MAX_OFFSET     = 16;
  localparam int unsigned MAX_ROW_PIXELS = 4096;
  localparam int unsigned HISTORY_DEPTH  = 2 * MAX_OFFSET + 1;
  // Settling time after a drain; it covers any beat still held in the output
  // register.
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned RANDOM_PIXELS  = 160;
  localparam int unsigned MAX_GAP        = 8;

  // One filter beat as it should appear on the output stream.
  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             row_done;
  } filter_beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts filter beats from accepted pixels and checks the
  // beats that the block delivers against them, in order.
  // --------------------------------------------------------------------------
  class row_filter_scoreboard;
    logic [PIX_W-1:0] history [HISTORY_DEPTH];
    logic [12:0]      column;
    logic [CFG_W-1:0] offset_reg;
    filter_beat_t     expected_q [$];
    int unsigned      errors;

    function new();
      for (int i = 0; i < HISTORY_DEPTH; i++) history[i] = '0;
      column     = '0;
      offset_reg = OFFSET_RESET;
      errors     = 0;
    endfunction

    function void set_offset(logic [CFG_W-1:0] value);
      offset_reg = value;
    endfunction

    // Zero behaves as one, anything above the maximum as the maximum.
    function int unsigned tau();
      if (offset_reg < 1) return 1;
      if (offset_reg > MAX_OFFSET) return MAX_OFFSET;
      return offset_reg;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // 2c - l - r - |l - r|, clamped to a gray level; a dark center gives 0.
    function logic [PIX_W-1:0] marking_response(logic [PIX_W-1:0] c,
                                                logic [PIX_W-1:0] l,
                                                logic [PIX_W-1:0] r);
      int diff;
      int acc;
      if (c == 0) return '0;
      diff = int'(l) - int'(r);
      if (diff < 0) diff = -diff;
      acc = 2 * int'(c) - int'(l) - int'(r) - diff;
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      return acc[PIX_W-1:0];
    endfunction

    function void push_beat(logic [PIX_W-1:0] value, logic row_done);
      filter_beat_t b;
      b.value    = value;
      b.row_done = row_done;
      expected_q.insert(expected_q.size(), b);
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pixel, logic row_end);
      int unsigned t;
      int unsigned flush;
      logic        closes_row;
      t = tau();
      // A row that reaches the length limit is closed as if marked.
      closes_row = row_end || (column >= MAX_ROW_PIXELS - 1);
      for (int i = HISTORY_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = pixel;
      // The new pixel is the right neighbour of the column t places back.
      if (column >= t) begin
        if (column >= 2 * t) begin
          push_beat(marking_response(history[t], history[2*t], history[0]), 1'b0);
        end else begin
          push_beat('0, 1'b0);
        end
      end
      if (closes_row) begin
        // Trailing columns come out as zeros, the last one marked.
        flush = (column >= t) ? t : column + 1;
        repeat (flush - 1) push_beat('0, 1'b0);
        push_beat('0, 1'b1);
        column = '0;
      end else begin
        column = column + 1'b1;
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] %s", $time, msg);
    endtask

    task check_beat(logic [PIX_W-1:0] value, logic row_done);
      filter_beat_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat value=%0d last=%0b", value, row_done));
      end else begin
        want = expected_q.pop_front();
        if (value !== want.value)
          report_mismatch($sformatf("value %0d, predicted %0d", value, want.value));
        if (row_done !== want.row_done)
          report_mismatch($sformatf("tlast %b, predicted %b", row_done, want.row_done));
      end
    endtask

    task check_drained();
      if (expected_q.size() != 0)
        report_mismatch($sformatf("%0d predicted beats never arrived", expected_q.size()));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block.
  // --------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic             pix_tvalid;
  logic             pix_tready;
  logic [7:0]       pix_tdata;
  logic             pix_tlast;
  logic             flt_tvalid;
  logic             flt_tready;
  logic [7:0]       flt_tdata;
  logic             flt_tlast;

  always #5 clk = ~clk;

  lane_marking_row_filter #(
    .MaxOffset   (MAX_OFFSET),
    .MaxRowPixels(MAX_ROW_PIXELS)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(pix_tvalid),
    .s_axis_tready(pix_tready),
    .s_axis_tdata (pix_tdata),
    .s_axis_tlast (pix_tlast),
    .m_axis_tvalid(flt_tvalid),
    .m_axis_tready(flt_tready),
    .m_axis_tdata (flt_tdata),
    .m_axis_tlast (flt_tlast)
  );

  row_filter_scoreboard sb = new();

  // Random idling on both sides is switched per phase, so that some phases
  // run back to back at full rate.
  bit gaps_on   = 1'b1;
  // Set by the stimulus to make the receiver hold off for a long stretch.
  bit hold_req  = 1'b0;
  // Tracks whether the pixel side is currently offering a beat.
  bit offering  = 1'b0;

  function automatic int unsigned draw_gap();
    return gaps_on ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  // Dark, saturated and dim pixels are drawn often so that the dark center
  // and both clamp limits come up regularly.
  function automatic logic [7:0] draw_pixel();
    case ($urandom_range(0, 9))
      0, 1:    return 8'd0;
      2, 3:    return 8'd255;
      4:       return 8'($urandom_range(1, 15));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offsets lean toward small values so that short rows still have columns
  // with both neighbours; zero and the values above the maximum appear too.
  function automatic logic [CFG_W-1:0] pick_offset();
    case ($urandom_range(0, 19))
      0:       return 5'd0;
      1:       return 5'd1;
      2:       return 5'd16;
      3:       return 5'd31;
      4:       return 5'($urandom_range(17, 30));
      5, 6, 7: return 5'($urandom_range(1, 16));
      default: return 5'($urandom_range(1, 6));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Pixel side. A beat stays offered until the block takes it; tvalid is only
  // dropped when the next beat is to wait, so it never toggles within a step.
  // --------------------------------------------------------------------------
  task automatic send_pixel(input logic [7:0] pixel, input logic row_end);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      if (offering) begin
        pix_tvalid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    pix_tvalid <= 1'b1;
    pix_tdata  <= pixel;
    pix_tlast  <= row_end;
    offering = 1'b1;
    do @(posedge clk); while (!pix_tready);
    sb.note_pixel(pixel, row_end);
  endtask

  task automatic send_row(input int unsigned length);
    for (int unsigned i = 0; i < length; i++) send_pixel(draw_pixel(), i == length - 1);
  endtask

  // Stops offering and waits until every predicted beat has come out, then
  // idles further so that the block is certainly at rest.
  task automatic drain();
    if (offering) begin
      pix_tvalid <= 1'b0;
      offering = 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic write_offset(input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_offset(value);
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Filter side. After each beat the receiver draws a stall; a hold request
  // replaces it with a long stall counted here.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    flt_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && flt_tvalid && flt_tready) begin
        sb.check_beat(flt_tdata, flt_tlast);
        stall_left = draw_gap();
      end
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req   = 1'b0;
      end
      if (stall_left > 0) begin
        flt_tready <= 1'b0;
        stall_left--;
      end else begin
        flt_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned random_pixels;
    int unsigned t;
    int unsigned length;
    logic [7:0]  first_row [13];

    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    pix_tvalid <= 1'b0;
    pix_tdata  <= '0;
    pix_tlast  <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset offset of five over a 13 pixel row: columns 5 to 7 are filtered.
    // Column 5 is a bright center between dark neighbours and saturates,
    // column 6 has a dark center, column 7 goes negative and clamps to zero.
    first_row = '{8'd0, 8'd255, 8'd255, 8'd255, 8'd255,
                  8'd255, 8'd0, 8'd100, 8'd255, 8'd255,
                  8'd0, 8'd255, 8'd0};
    for (int i = 0; i < 13; i++) send_pixel(first_row[i], i == 12);
    drain();

    // An offset of zero acts as one.
    write_offset(5'd0);
    send_pixel(8'd10, 1'b0);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd30, 1'b0);
    send_pixel(8'd255, 1'b1);
    drain();

    // The largest code acts as the maximum offset; rows far shorter than the
    // window give only zeros, all at their last pixel.
    write_offset(5'd31);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd128, 1'b1);
    send_pixel(8'd255, 1'b1);
    drain();

    write_offset(5'd16);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b1);
    drain();

    // Back pressure: the receiver holds off while a full-rate row is offered,
    // so the block fills up and stops taking pixels.
    gaps_on = 1'b0;
    write_offset(5'd3);
    hold_req = 1'b1;
    send_row(60);
    drain();

    // Random groups of rows, each under a new offset, most of them long
    // enough to have filtered columns.
    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      write_offset(pick_offset());
      t = sb.tau();
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 4) == 0) length = $urandom_range(1, 2 * t);
        else length = $urandom_range(2 * t + 1, 2 * t + 24);
        send_row(length);
        random_pixels += length;
      end
      drain();
    end

    sb.check_drained();
    if (sb.errors == 0) begin
      $display("lane_marking_row_filter: match");
    end else begin
      $display("lane_marking_row_filter: mismatch");
    end
    $finish;
  end

  // Far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("lane_marking_row_filter: mismatch");
    $finish;
  end

endmodule

[sim.f]
sv/lmrf_pkg.sv
sv/lmrf_ram.sv
sv/lmrf_front.sv
sv/lmrf_emit.sv
sv/lane_marking_row_filter.sv
dv/tb.sv
